[src/evpd_pkg.sv]
// ----------------------------------------------------------------------------
// evpd_pkg
// Shared types, character codes and helpers for the ext-value percent decoder.
// ----------------------------------------------------------------------------
package evpd_pkg;

    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_APOS   = 2'd1;
    localparam logic [1:0] ST_XTRA_APOS = 2'd2;
    localparam logic [1:0] ST_BAD_ESC   = 2'd3;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last_result;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r1;
        t_res       r0;
    } t_push;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_0 && c <= CH_9) begin
                d = c - CH_0;
                nibble_of = {1'b0, d[3:0]};
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA;
                nibble_of = {1'b0, d[3:0] + HEX_TEN};
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA;
                nibble_of = {1'b0, d[3:0] + HEX_TEN};
            end else begin
                nibble_of = 5'h10;
            end
        end
    endfunction

endpackage

[src/evpd_core.sv]
// ----------------------------------------------------------------------------
// evpd_core
// Decode state and per-word decode logic; yields zero to two results per word.
// ----------------------------------------------------------------------------
module evpd_core import evpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_string,
    output t_push      o_push
);

    logic [1:0] r_ap, n_ap;
    logic [1:0] r_ph, n_ph;
    logic [7:0] r_held, n_held;
    logic [1:0] r_err, n_err;

    always_comb begin
        logic [4:0] hi;
        logic [4:0] lo;
        hi     = nibble_of(r_held);
        lo     = nibble_of(i_data_byte);
        n_ap   = r_ap;
        n_ph   = r_ph;
        n_held = r_held;
        n_err  = r_err;
        o_push = '0;

        if (i_byte_present && r_err == ST_OK) begin
            if (r_ap < 2'd2) begin
                if (i_data_byte == CH_APOS) begin
                    n_ap = r_ap + 2'd1;
                end
            end else if (i_data_byte == CH_APOS) begin
                n_err = ST_XTRA_APOS;
                n_ph  = PH_NONE;
            end else begin
                case (r_ph)
                    PH_PCT: begin
                        n_held = i_data_byte;
                        n_ph   = PH_HELD;
                    end
                    PH_HELD: begin
                        n_ph = PH_NONE;
                        if (hi[4] || lo[4]) begin
                            n_err = ST_BAD_ESC;
                        end else begin
                            o_push.n            = 2'd1;
                            o_push.r0.out_byte  = {hi[3:0], lo[3:0]};
                            o_push.r0.out_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_ph = PH_NONE;
                        if (i_data_byte == CH_PERCENT) begin
                            n_ph = PH_PCT;
                        end else begin
                            o_push.n            = 2'd1;
                            o_push.r0.out_byte  = i_data_byte;
                            o_push.r0.out_valid = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (i_end_of_string) begin
            // a byte emitted above leaves no escape pending, so slots never clash
            if (n_err == ST_OK) begin
                if (n_ap < 2'd2) begin
                    n_err = ST_NO_APOS;
                end else if (n_ph == PH_PCT) begin
                    o_push.n            = 2'd1;
                    o_push.r0.out_byte  = CH_PERCENT;
                    o_push.r0.out_valid = 1'b1;
                end else if (n_ph == PH_HELD) begin
                    o_push.n            = 2'd2;
                    o_push.r0.out_byte  = CH_PERCENT;
                    o_push.r0.out_valid = 1'b1;
                    o_push.r1.out_byte  = n_held;
                    o_push.r1.out_valid = 1'b1;
                end
            end
            if (o_push.n == 2'd2) begin
                o_push.r1.last_result = 1'b1;
                o_push.r1.status      = n_err;
            end else begin
                o_push.n              = 2'd1;
                o_push.r0.last_result = 1'b1;
                o_push.r0.status      = n_err;
            end
            n_ap  = 2'd0;
            n_ph  = PH_NONE;
            n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap  <= 2'd0;
            r_ph  <= PH_NONE;
            r_err <= ST_OK;
        end else if (i_accept) begin
            r_ap  <= n_ap;
            r_ph  <= n_ph;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

[src/evpd_fifo.sv]
// ----------------------------------------------------------------------------
// evpd_fifo
// Four-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module evpd_fifo import evpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_en,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);

    t_res       r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] push_n;
    logic       pop;

    assign push_n  = i_push_en ? i_push.n : 2'd0;
    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt <= 3'd2);
    assign o_res   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + push_n;
        n_rp  = r_rp + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.r1;
        end
    end

endmodule

[src/ext_value_percent_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ext_value_percent_decoder_unit
// Percent decoder for charset'language'value extended parameter values.
// ----------------------------------------------------------------------------
// Slave stream: one raw byte per word; tuser flags a real byte (0 = bare end
// marker), tlast marks the end of the value. Bytes up to the second
// apostrophe are dropped, %XX escapes become one byte, others pass through.
// Master stream: one decoded byte per word, tuser bit 0 says the byte is
// real, tuser bits 2:1 carry the status on the tlast word (0 ok, 1 missing
// apostrophe, 2 extra apostrophe, 3 bad escape). On error the consumer drops
// the bytes of that value already taken.
// Each result is registered in the result queue before it reaches the master stream.
// Throughput: one word per cycle in both directions while neither stream stalls;
// an end word that flushes a held escape yields two results.
// A four-entry result queue decouples the sides: s_tready drops only when
// fewer than two entries are free, so a stalled receiver backs up the input
// once three results wait and nothing is lost.
// Reset (synchronous, active low) empties the queue and clears decode state.
// ----------------------------------------------------------------------------
module ext_value_percent_decoder_unit import evpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // [0] byte_present
    input  logic       i_s_tlast,   // end_of_string
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [2:0] o_m_tuser,   // [0] out_valid, [2:1] status
    output logic       o_m_tlast    // last_result
);

    logic  accept;
    logic  room;
    t_push push;
    t_res  res;

    assign o_s_tready = room;
    assign accept     = i_s_tvalid && room;

    evpd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_s_tdata),
        .i_byte_present  (i_s_tuser),
        .i_end_of_string (i_s_tlast),
        .o_push          (push)
    );

    evpd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (res)
    );

    assign o_m_tdata = res.out_byte;
    assign o_m_tuser = {res.status, res.out_valid};
    assign o_m_tlast = res.last_result;

endmodule

[tb/sv/evpd_checker.sv]
// ----------------------------------------------------------------------------
// evpd_checker
// Decodes the accepted input words of the ext-value percent decoder on its
// own, queues the words it expects on the master stream and compares every
// accepted output word field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module evpd_checker import evpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // [0] byte_present
    input  logic       i_s_tlast,   // end_of_string
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  logic [2:0] i_m_tuser,   // [0] out_valid, [2:1] status
    input  logic       i_m_tlast,   // last_result
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0] apos_count;
    logic [1:0] esc_phase;
    logic [7:0] held_byte;
    logic [1:0] err_code;
    t_res       decoded_q[$];
    t_res       got_word;
    t_res       want_word;
    int         fail_count = 0;

    // bit 4 flags a non-hex character
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CH_0 && c <= CH_9)
            return {1'b0, c[3:0]};
        if (folded >= CH_LA && folded <= CH_LF)
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    task automatic clear_decoder();
        apos_count = 2'd0;
        esc_phase  = PH_NONE;
        held_byte  = 8'd0;
        err_code   = ST_OK;
    endtask

    task automatic queue_word(input t_res w);
        decoded_q.insert(decoded_q.size(), w);
    endtask

    task automatic push_byte(input logic [7:0] b);
        queue_word({b, 1'b1, 1'b0, ST_OK});
    endtask

    task automatic decode_word(input logic [7:0] b, input logic present, input logic eos);
        int         base;
        logic [4:0] hi;
        logic [4:0] lo;
        t_res       tail;
        base = decoded_q.size();
        if (present && err_code == ST_OK) begin
            if (apos_count < 2'd2) begin
                if (b == CH_APOS)
                    apos_count = apos_count + 2'd1;
            end else if (b == CH_APOS) begin
                err_code  = ST_XTRA_APOS;
                esc_phase = PH_NONE;
            end else if (esc_phase == PH_PCT) begin
                held_byte = b;
                esc_phase = PH_HELD;
            end else if (esc_phase == PH_HELD) begin
                hi        = hex_nibble(held_byte);
                lo        = hex_nibble(b);
                esc_phase = PH_NONE;
                if (hi[4] || lo[4])
                    err_code = ST_BAD_ESC;
                else
                    push_byte({hi[3:0], lo[3:0]});
            end else if (b == CH_PERCENT) begin
                esc_phase = PH_PCT;
            end else begin
                esc_phase = PH_NONE;
                push_byte(b);
            end
        end
        if (eos) begin
            if (err_code == ST_OK) begin
                if (apos_count < 2'd2) begin
                    err_code = ST_NO_APOS;
                end else if (esc_phase == PH_PCT) begin
                    push_byte(CH_PERCENT);
                end else if (esc_phase == PH_HELD) begin
                    push_byte(CH_PERCENT);
                    push_byte(held_byte);
                end
            end
            if (decoded_q.size() == base)
                queue_word({8'd0, 1'b0, 1'b0, ST_OK});
            tail             = decoded_q[$];
            tail.last_result = 1'b1;
            tail.status      = err_code;
            decoded_q[$]     = tail;
            clear_decoder();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
        end else begin
            if (i_s_tvalid && i_s_tready)
                decode_word(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got_word = {i_m_tdata, i_m_tuser[0], i_m_tlast, i_m_tuser[2:1]};
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none,", $time,
                             " actual byte %h valid %b last %b status %0d",
                             got_word.out_byte, got_word.out_valid,
                             got_word.last_result, got_word.status);
                end else begin
                    want_word = decoded_q.pop_front();
                    if (got_word.out_byte !== want_word.out_byte ||
                        got_word.out_valid !== want_word.out_valid ||
                        got_word.last_result !== want_word.last_result ||
                        got_word.status !== want_word.status) begin
                        fail_count++;
                        $display("%0t: expected byte %h valid %b last %b status %0d,",
                                 $time, want_word.out_byte, want_word.out_valid,
                                 want_word.last_result, want_word.status,
                                 " actual byte %h valid %b last %b status %0d",
                                 got_word.out_byte, got_word.out_valid,
                                 got_word.last_result, got_word.status);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= decoded_q.size();
    end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the ext-value percent decoder: a directed opening that walks
// through escapes, flushes at the end, and every error status, then random
// values, mostly well formed with random content, some noise. Both streams
// stall at random; a checker beside the block scores the output.
// ----------------------------------------------------------------------------
module tb_top;
    import evpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_COUNT = 600;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    logic       steady   = 1'b0;
    int         fail_count;
    int         pending;
    int         words_sent = 0;

    ext_value_percent_decoder_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    evpd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 34);

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_APOS || b == CH_PERCENT);
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return CH_0 + 8'(v);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(3);
        if (r == 0)
            return CH_APOS;
        if (r == 1)
            return CH_PERCENT;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic present, input logic eos);
        while (!steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (present || eos)
            words_sent++;
    endtask

    task automatic send_token();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            send_word(plain_byte(), 1'b1, 1'b0);
        end else if (r < 85) begin
            send_word(CH_PERCENT, 1'b1, 1'b0);
            send_word(hex_char(), 1'b1, 1'b0);
            send_word(hex_char(), 1'b1, 1'b0);
        end else if (r < 90) begin
            send_word(CH_PERCENT, 1'b1, 1'b0);
            if ($urandom_range(1)) begin
                send_word(8'($urandom_range(255, CH_LF + 1)), 1'b1, 1'b0);
                send_word(hex_char(), 1'b1, 1'b0);
            end else begin
                send_word(hex_char(), 1'b1, 1'b0);
                send_word(8'($urandom_range(255, CH_LF + 1)), 1'b1, 1'b0);
            end
        end else if (r < 94) begin
            send_word(CH_APOS, 1'b1, 1'b0);
        end else if (r < 97) begin
            send_word(8'($urandom_range(255)), 1'b0, 1'b0);
        end else begin
            send_word(CH_PERCENT, 1'b1, 1'b0);
            send_word(CH_APOS, 1'b1, 1'b0);
        end
    endtask

    task automatic send_random_value();
        int n;
        int i;
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(8, 1);
            for (i = 0; i < n; i++)
                send_word(noise_byte(), 1'($urandom_range(1)), 1'(i == n - 1));
        end else begin
            n = $urandom_range(4);
            for (i = 0; i < n; i++)
                send_word(plain_byte(), 1'b1, 1'b0);
            send_word(CH_APOS, 1'b1, 1'b0);
            n = $urandom_range(3);
            for (i = 0; i < n; i++)
                send_word(plain_byte(), 1'b1, 1'b0);
            if ($urandom_range(19) != 0)
                send_word(CH_APOS, 1'b1, 1'b0);
            n = $urandom_range(10);
            for (i = 0; i < n; i++)
                send_token();
            case ($urandom_range(4))
                0: send_word(8'($urandom_range(255)), 1'b0, 1'b1);
                1: send_word(plain_byte(), 1'b1, 1'b1);
                2: send_word(CH_PERCENT, 1'b1, 1'b1);
                3: begin
                    send_word(CH_PERCENT, 1'b1, 1'b0);
                    send_word(hex_char(), 1'b1, 1'b1);
                end
                default: begin
                    send_word(CH_PERCENT, 1'b1, 1'b0);
                    send_word(hex_char(), 1'b1, 1'b0);
                    send_word(hex_char(), 1'b1, 1'b1);
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, both hex cases, idle word, held escape flushed at the end
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(CH_PERCENT, 1'b1, 1'b0);
        send_word(CH_LA, 1'b1, 1'b0);
        send_word(CH_UF, 1'b1, 1'b0);
        send_word(CH_PERCENT, 1'b1, 1'b0);
        send_word(CH_0, 1'b1, 1'b0);
        send_word(CH_9, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(CH_PERCENT, 1'b1, 1'b0);
        send_word(8'h47, 1'b1, 1'b1);
        // bare end with no apostrophes
        send_word(8'hA5, 1'b0, 1'b1);
        // bad escape, later bytes suppressed
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_PERCENT, 1'b1, 1'b0);
        send_word(8'h7A, 1'b1, 1'b0);
        send_word(CH_0 + 8'd1, 1'b1, 1'b0);
        send_word(CH_APOS, 1'b1, 1'b1);
        // third apostrophe inside an escape
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_PERCENT, 1'b1, 1'b0);
        send_word(CH_APOS, 1'b1, 1'b1);
        // lone percent at the end
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_APOS, 1'b1, 1'b0);
        send_word(CH_PERCENT, 1'b1, 1'b1);

        while (words_sent < WORD_COUNT) begin
            steady <= (words_sent >= 250 && words_sent < 350);
            send_random_value();
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
